[hdl/e2q_pkg.sv]
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared constants, types and tables for the Euler to quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int ANGLE_WIDTH = 16;
  localparam int QUAT_WIDTH = 16;
  localparam int CORDIC_ITERS = 18;
  localparam int ITER_WIDTH = $clog2(CORDIC_ITERS);
  localparam int CW = 33;
  localparam int ZW = 34;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [QUAT_WIDTH-1:0] QUAT_ONE = 16'sd16384;

  typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
  typedef logic signed [QUAT_WIDTH-1:0] quat_t;
  typedef logic signed [CW-1:0] trig_t;
  typedef logic signed [ZW-1:0] phase_t;

  typedef struct packed {
    trig_t c;
    trig_t s;
  } cs_t;

  function automatic phase_t atan_entry(input logic [ITER_WIDTH-1:0] i);
    phase_t r;
    r = '0;
    case (i)
      5'd0: r = 34'sd843314856;
      5'd1: r = 34'sd497837829;
      5'd2: r = 34'sd263043836;
      5'd3: r = 34'sd133525158;
      5'd4: r = 34'sd67021686;
      5'd5: r = 34'sd33543515;
      5'd6: r = 34'sd16775850;
      5'd7: r = 34'sd8388437;
      5'd8: r = 34'sd4194282;
      5'd9: r = 34'sd2097149;
      5'd10: r = 34'sd1048575;
      5'd11: r = 34'sd524287;
      5'd12: r = 34'sd262143;
      5'd13: r = 34'sd131071;
      5'd14: r = 34'sd65535;
      5'd15: r = 34'sd32767;
      5'd16: r = 34'sd16383;
      5'd17: r = 34'sd8191;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[hdl/e2q_if.sv]
// ----------------------------------------------------------------------------
// e2q_if
// Valid/ready channel interfaces for angle input and quaternion output.
// ----------------------------------------------------------------------------
interface e2q_angle_if;
  logic valid;
  logic ready;
  e2q_pkg::angle_t yaw_angle;
  e2q_pkg::angle_t pitch_angle;
  e2q_pkg::angle_t roll_angle;
  modport source (output valid, yaw_angle, pitch_angle, roll_angle, input ready);
  modport sink (input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

interface e2q_quat_if;
  logic valid;
  logic ready;
  e2q_pkg::quat_t quat_w;
  e2q_pkg::quat_t quat_x;
  e2q_pkg::quat_t quat_y;
  e2q_pkg::quat_t quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

[hdl/euler_to_quaternion.sv]
// ----------------------------------------------------------------------------
// euler_to_quaternion
// ZYX Euler angles (Q3.13) to unit quaternion (Q1.14), fully pipelined.
// ----------------------------------------------------------------------------
// Takes one item per cycle unless the output stalls. Stages: a fold stage and
// 18 CORDIC rotation stages per angle, three multiply/round stages, and an
// output register. The whole pipe advances when the output register is empty
// or being taken; valid bits move with the data, so a stall holds everything.
module euler_to_quaternion (
  input  logic          clk,
  input  logic          rst,
  e2q_angle_if.sink     in_ch,
  e2q_quat_if.source    out_ch
);

  localparam int DEPTH = e2q_pkg::CORDIC_ITERS + 4;

  logic [DEPTH-1:0] vld;
  logic en;
  e2q_pkg::cs_t cy, cp, cr;
  e2q_pkg::quat_t qw, qx, qy, qz;

  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_ch.valid <= 1'b0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_ch.valid};
      out_ch.valid <= vld[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.quat_w <= qw;
      out_ch.quat_x <= qx;
      out_ch.quat_y <= qy;
      out_ch.quat_z <= qz;
    end
  end

  e2q_cordic u_yaw (.clk, .en, .angle(in_ch.yaw_angle), .cs(cy));
  e2q_cordic u_pitch (.clk, .en, .angle(in_ch.pitch_angle), .cs(cp));
  e2q_cordic u_roll (.clk, .en, .angle(in_ch.roll_angle), .cs(cr));

  e2q_combine u_comb (
    .clk, .en, .yaw(cy), .pitch(cp), .roll(cr),
    .quat_w(qw), .quat_x(qx), .quat_y(qy), .quat_z(qz)
  );

endmodule

[hdl/e2q_cordic.sv]
// ----------------------------------------------------------------------------
// e2q_cordic
// Pipelined rotation-mode CORDIC: half angle in, cosine and sine out in Q.30.
// One stage per rotation plus a range-fold stage; advances on the enable.
// ----------------------------------------------------------------------------
module e2q_cordic (
  input  logic                clk,
  input  logic                en,
  input  e2q_pkg::angle_t     angle,
  output e2q_pkg::cs_t        cs
);

  localparam int N = e2q_pkg::CORDIC_ITERS;

  e2q_pkg::trig_t  x [N+1];
  e2q_pkg::trig_t  y [N+1];
  e2q_pkg::phase_t z [N+1];
  logic            flip [N+1];

  e2q_pkg::phase_t half;

  function automatic logic [e2q_pkg::ITER_WIDTH-1:0] ITER_WIDTH_CAST(input int v);
    return v[e2q_pkg::ITER_WIDTH-1:0];
  endfunction

  assign half = e2q_pkg::phase_t'(angle) <<< (32 - e2q_pkg::ANGLE_WIDTH);

  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= e2q_pkg::CORDIC_GAIN;
      y[0] <= '0;
      if (half > e2q_pkg::HALF_PI_Q30) begin
        z[0] <= half - e2q_pkg::PI_Q30;
        flip[0] <= 1'b1;
      end else if (half < -e2q_pkg::HALF_PI_Q30) begin
        z[0] <= half + e2q_pkg::PI_Q30;
        flip[0] <= 1'b1;
      end else begin
        z[0] <= half;
        flip[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        flip[i+1] <= flip[i];
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - e2q_pkg::atan_entry(ITER_WIDTH_CAST(i));
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + e2q_pkg::atan_entry(ITER_WIDTH_CAST(i));
        end
      end
    end
  end

  assign cs.c = flip[N] ? -x[N] : x[N];
  assign cs.s = flip[N] ? -y[N] : y[N];

endmodule

[hdl/e2q_combine.sv]
// ----------------------------------------------------------------------------
// e2q_combine
// Triple-product quaternion combine: pair products rounded to Q.30, then
// triple products, sums rounded to Q1.14 and saturated. Three stages.
// ----------------------------------------------------------------------------
module e2q_combine (
  input  logic             clk,
  input  logic             en,
  input  e2q_pkg::cs_t     yaw,
  input  e2q_pkg::cs_t     pitch,
  input  e2q_pkg::cs_t     roll,
  output e2q_pkg::quat_t   quat_w,
  output e2q_pkg::quat_t   quat_x,
  output e2q_pkg::quat_t   quat_y,
  output e2q_pkg::quat_t   quat_z
);

  localparam int PW = 2 * e2q_pkg::CW;
  localparam int TW = PW + 1;
  localparam int RW = TW - 46;
  localparam logic signed [PW-1:0] RND30 = PW'(64'sd536870912);
  localparam logic signed [TW-1:0] RND46 = TW'(64'sd35184372088832);

  // pair products: cy*cp, sy*sp, sy*cp, cy*sp
  logic signed [PW-1:0] p_raw [4];
  e2q_pkg::trig_t pair [4];
  e2q_pkg::cs_t   roll_d;
  logic signed [PW-1:0] t [8];
  logic signed [TW-1:0] sum [4];

  always_comb begin
    p_raw[0] = PW'(yaw.c) * PW'(pitch.c) + RND30;
    p_raw[1] = PW'(yaw.s) * PW'(pitch.s) + RND30;
    p_raw[2] = PW'(yaw.s) * PW'(pitch.c) + RND30;
    p_raw[3] = PW'(yaw.c) * PW'(pitch.s) + RND30;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        pair[k] <= e2q_pkg::trig_t'(p_raw[k] >>> 30);
      end
      roll_d <= roll;
      t[0] <= PW'(pair[0]) * PW'(roll_d.c);
      t[1] <= PW'(pair[1]) * PW'(roll_d.s);
      t[2] <= PW'(pair[0]) * PW'(roll_d.s);
      t[3] <= PW'(pair[1]) * PW'(roll_d.c);
      t[4] <= PW'(pair[2]) * PW'(roll_d.s);
      t[5] <= PW'(pair[3]) * PW'(roll_d.c);
      t[6] <= PW'(pair[2]) * PW'(roll_d.c);
      t[7] <= PW'(pair[3]) * PW'(roll_d.s);
      sum[0] <= TW'(t[0]) + TW'(t[1]) + RND46;
      sum[1] <= TW'(t[2]) - TW'(t[3]) + RND46;
      sum[2] <= TW'(t[4]) + TW'(t[5]) + RND46;
      sum[3] <= TW'(t[6]) - TW'(t[7]) + RND46;
    end
  end

  function automatic e2q_pkg::quat_t sat(input logic signed [TW-1:0] v);
    logic signed [RW-1:0] r;
    r = RW'(v >>> 46);
    if (r > RW'(e2q_pkg::QUAT_ONE)) return e2q_pkg::QUAT_ONE;
    if (r < -RW'(e2q_pkg::QUAT_ONE)) return -e2q_pkg::QUAT_ONE;
    return e2q_pkg::quat_t'(r);
  endfunction

  assign quat_w = sat(sum[0]);
  assign quat_x = sat(sum[1]);
  assign quat_y = sat(sum[2]);
  assign quat_z = sat(sum[3]);

endmodule
